### hw/rtl/dqi_pkg.sv
// Shared types, constants and the per-level insert function of the dedup queue insert block.
package dqi_pkg;

  localparam int NUM_ENTRIES = 1024;
  localparam int QUEUE_DEPTH = 1024;
  localparam int FLAG_AW     = $clog2(NUM_ENTRIES);
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam int ENTRY_W = 10;
  localparam int CNT_W   = 11;
  localparam int FLAG_W  = 4;
  localparam int CFG_IW  = 2;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  localparam logic [CNT_W-1:0] ACTIVE_COUNT_RST = '0;
  localparam logic [CNT_W-1:0] CAPACITY_RST     = CNT_W'(1024);

  typedef enum logic [CFG_IW-1:0] {
    CFG_ACTIVE_COUNT    = 2'd0,
    CFG_CAPACITY_LEVEL1 = 2'd1,
    CFG_CAPACITY_LEVEL2 = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OUT_ALREADY = 2'd0,
    OUT_COMMIT  = 2'd1,
    OUT_PENDING = 2'd2,
    OUT_DROPPED = 2'd3
  } outcome_e;

  typedef struct packed {
    logic clear;
    logic load;
    logic commit;
  } dqi_cmd_t;

  typedef struct packed {
    logic clear_last;
  } dqi_sts_t;

  typedef struct packed {
    logic [1:0]          pair;       // bit0 committed, bit1 pending
    logic [CNT_W-1:0]    committed;
    logic [CNT_W-1:0]    total;
    outcome_e            outcome;
    logic                wr_en;
    logic [QUEUE_AW-1:0] wr_addr;
  } level_res_t;

  function automatic level_res_t level_insert(input logic [1:0]       pair,
                                              input logic [CNT_W-1:0] committed,
                                              input logic [CNT_W-1:0] total,
                                              input logic [CNT_W-1:0] cap_raw,
                                              input logic             active);
    level_res_t       r;
    logic [CNT_W-1:0] cap;
    logic [CNT_W-1:0] pos;
    r.pair      = pair;
    r.committed = committed;
    r.total     = total;
    r.outcome   = OUT_ALREADY;
    r.wr_en     = 1'b0;
    cap = (32'(cap_raw) > QUEUE_DEPTH) ? CNT_W'(QUEUE_DEPTH) : cap_raw;
    pos = active ? total : committed;
    r.wr_addr = QUEUE_AW'(pos);
    if (pair == 2'b00) begin
      if (pos < cap) begin
        r.wr_en = 1'b1;
        if (total != COUNT_MAX) begin
          r.total = total + CNT_W'(1);
        end
        if (active) begin
          r.outcome = OUT_PENDING;
        end else begin
          r.committed = committed + CNT_W'(1);
          r.pair[0]   = 1'b1;
          r.outcome   = OUT_COMMIT;
        end
      end else begin
        r.outcome = OUT_DROPPED;
      end
    end
    if (active) begin
      r.pair[1] = 1'b1;
    end
    return r;
  endfunction

endpackage

### hw/rtl/two_level_dedup_queue_insert.sv
// Top level of the two-level deduplicating queue insert block.
//
// Each input word names one entry and the active flag of two levels. An
// index below the active count is appended to the level one and level two
// queues unless its flags show it already queued at that level: an inactive
// level appends to the committed section (committed and total counts both
// rise), an active level to the pending section (only the total rises), and
// a full queue drops the append. Every word yields one result word with the
// two outcomes, the entry's new flags and the four counts after the step.
// An item passes through a read state and an update state: the per-entry
// flags live in a single-port RAM that is read in the first and written back
// in the second. The next word can be taken as the update commits. A finished
// result waits in an output register, so the next word is taken while it
// waits; only when the result register is still full at the end of an item
// does the update hold. After reset the block sweeps all 1024 entries of the
// flag RAM to zero, one entry per cycle; in_ready_o stays low during the
// sweep while configuration writes are taken as always. cfg_ready_o is always high.
module two_level_dedup_queue_insert (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [dqi_pkg::ENTRY_W-1:0] entry_index_i,
  input  logic                        level1_active_i,
  input  logic                        level2_active_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        index_rejected_o,
  output logic [1:0]                  level1_outcome_o,
  output logic [1:0]                  level2_outcome_o,
  output logic [dqi_pkg::FLAG_W-1:0]  new_flags_o,
  output logic [dqi_pkg::CNT_W-1:0]   level1_committed_count_o,
  output logic [dqi_pkg::CNT_W-1:0]   level1_total_count_o,
  output logic [dqi_pkg::CNT_W-1:0]   level2_committed_count_o,
  output logic [dqi_pkg::CNT_W-1:0]   level2_total_count_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [dqi_pkg::CFG_IW-1:0]  cfg_index_i,
  input  logic [dqi_pkg::CNT_W-1:0]   cfg_data_i
);
  import dqi_pkg::*;

  dqi_cmd_t cmd;
  dqi_sts_t sts;

  // Config registers take a write in any cycle
  assign cfg_ready_o = 1'b1;

  // Sequencer: clear sweep, then read / update per word
  dqi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // Memories, counts and result word
  dqi_datapath u_datapath (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .cmd_i                   (cmd),
    .sts_o                   (sts),
    .cfg_valid_i             (cfg_valid_i),
    .cfg_index_i             (cfg_index_i),
    .cfg_data_i              (cfg_data_i),
    .entry_index_i           (entry_index_i),
    .level1_active_i         (level1_active_i),
    .level2_active_i         (level2_active_i),
    .index_rejected_o        (index_rejected_o),
    .level1_outcome_o        (level1_outcome_o),
    .level2_outcome_o        (level2_outcome_o),
    .new_flags_o             (new_flags_o),
    .level1_committed_count_o(level1_committed_count_o),
    .level1_total_count_o    (level1_total_count_o),
    .level2_committed_count_o(level2_committed_count_o),
    .level2_total_count_o    (level2_total_count_o)
  );

endmodule

### hw/rtl/dqi_ram.sv
// Generic single-port RAM with registered read data.
module dqi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/dqi_ctrl.sv
// Sequencer of the dedup queue insert: flag clear sweep, flag read, update and result hand-off.
module dqi_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output dqi_pkg::dqi_cmd_t cmd_o,
  input  dqi_pkg::dqi_sts_t sts_i
);
  import dqi_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_READ  = 4'b0100,
    S_WRITE = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   accept;
  logic   commit;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) || ((state_q == S_WRITE) && out_free);
  assign accept     = in_valid_i && in_ready_o;
  assign commit     = (state_q == S_WRITE) && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (sts_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_WRITE;
      end
      S_WRITE: begin
        if (out_free) begin
          state_d = accept ? S_READ : S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cmd_o.clear  = (state_q == S_CLEAR);
  assign cmd_o.load   = accept;
  assign cmd_o.commit = commit;

  a_accept_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_READ))
    else $error("accepted word not followed by flag read");

  a_read_then_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |=> (state_q == S_WRITE))
    else $error("flag read not followed by update");

  a_result_from_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_WRITE))
    else $error("result raised outside update state");

  a_clear_ends_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_CLEAR) && sts_i.clear_last) |=> (state_q == S_IDLE))
    else $error("clear sweep did not end in idle");

endmodule

### hw/rtl/dqi_datapath.sv
// Datapath of the dedup queue insert: config, flag and queue memories, counts, result register.
module dqi_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dqi_pkg::dqi_cmd_t           cmd_i,
  output dqi_pkg::dqi_sts_t           sts_o,
  input  logic                        cfg_valid_i,
  input  logic [dqi_pkg::CFG_IW-1:0]  cfg_index_i,
  input  logic [dqi_pkg::CNT_W-1:0]   cfg_data_i,
  input  logic [dqi_pkg::ENTRY_W-1:0] entry_index_i,
  input  logic                        level1_active_i,
  input  logic                        level2_active_i,
  output logic                        index_rejected_o,
  output logic [1:0]                  level1_outcome_o,
  output logic [1:0]                  level2_outcome_o,
  output logic [dqi_pkg::FLAG_W-1:0]  new_flags_o,
  output logic [dqi_pkg::CNT_W-1:0]   level1_committed_count_o,
  output logic [dqi_pkg::CNT_W-1:0]   level1_total_count_o,
  output logic [dqi_pkg::CNT_W-1:0]   level2_committed_count_o,
  output logic [dqi_pkg::CNT_W-1:0]   level2_total_count_o
);
  import dqi_pkg::*;

  logic [CNT_W-1:0]   active_count_q, cap1_q, cap2_q;
  logic [FLAG_AW-1:0] clr_q;
  logic [ENTRY_W-1:0] idx_q;
  logic               act1_q, act2_q;
  logic [CNT_W-1:0]   c1_q, t1_q, c2_q, t2_q;
  logic [CNT_W-1:0]   c1_d, t1_d, c2_d, t2_d;

  logic               rej_q;
  logic [1:0]         oc1_q, oc2_q;
  logic [FLAG_W-1:0]  flags_q;
  logic [CNT_W-1:0]   rc1_q, rt1_q, rc2_q, rt2_q;

  logic [FLAG_W-1:0]  flags_rd;
  logic [FLAG_W-1:0]  new_flags;
  logic               rejected;
  level_res_t         l1, l2;

  logic               flag_we;
  logic [FLAG_AW-1:0] flag_addr;
  logic [FLAG_W-1:0]  flag_wdata;
  logic               q1_we, q2_we;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_count_q <= ACTIVE_COUNT_RST;
      cap1_q         <= CAPACITY_RST;
      cap2_q         <= CAPACITY_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ACTIVE_COUNT:    active_count_q <= cfg_data_i;
        CFG_CAPACITY_LEVEL1: cap1_q         <= cfg_data_i;
        CFG_CAPACITY_LEVEL2: cap2_q         <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clear sweep address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear) begin
      clr_q <= clr_q + FLAG_AW'(1);
    end
  end
  assign sts_o.clear_last = (clr_q == FLAG_AW'(NUM_ENTRIES - 1));

  // Captured input word
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      idx_q  <= entry_index_i;
      act1_q <= level1_active_i;
      act2_q <= level2_active_i;
    end
  end

  assign rejected = !(({1'b0, idx_q} < active_count_q) && (32'(idx_q) < NUM_ENTRIES));

  always_comb begin
    l1 = level_insert(flags_rd[1:0], c1_q, t1_q, cap1_q, act1_q);
    l2 = level_insert(flags_rd[3:2], c2_q, t2_q, cap2_q, act2_q);
    new_flags = {l2.pair, l1.pair};
  end

  always_comb begin
    c1_d = c1_q;
    t1_d = t1_q;
    c2_d = c2_q;
    t2_d = t2_q;
    if (cmd_i.commit && !rejected) begin
      c1_d = l1.committed;
      t1_d = l1.total;
      c2_d = l2.committed;
      t2_d = l2.total;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0;
      t1_q <= '0;
      c2_q <= '0;
      t2_q <= '0;
    end else begin
      c1_q <= c1_d;
      t1_q <= t1_d;
      c2_q <= c2_d;
      t2_q <= t2_d;
    end
  end

  // Result register; counts show the values after the step
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      rej_q   <= rejected;
      oc1_q   <= rejected ? OUT_ALREADY : l1.outcome;
      oc2_q   <= rejected ? OUT_ALREADY : l2.outcome;
      flags_q <= rejected ? '0 : new_flags;
      rc1_q   <= c1_d;
      rt1_q   <= t1_d;
      rc2_q   <= c2_d;
      rt2_q   <= t2_d;
    end
  end

  // Flag memory: sweep to zero after reset, read on the cycle after capture, write back on commit
  assign flag_we    = cmd_i.clear || (cmd_i.commit && !rejected);
  assign flag_addr  = cmd_i.clear ? clr_q : FLAG_AW'(idx_q);
  assign flag_wdata = cmd_i.clear ? '0 : new_flags;

  dqi_ram #(
    .WIDTH(FLAG_W),
    .DEPTH(NUM_ENTRIES)
  ) u_flag_ram (
    .clk_i  (clk_i),
    .we_i   (flag_we),
    .addr_i (flag_addr),
    .wdata_i(flag_wdata),
    .rdata_o(flags_rd)
  );

  assign q1_we = cmd_i.commit && !rejected && l1.wr_en;
  assign q2_we = cmd_i.commit && !rejected && l2.wr_en;

  dqi_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue1_ram (
    .clk_i  (clk_i),
    .we_i   (q1_we),
    .addr_i (l1.wr_addr),
    .wdata_i(idx_q),
    .rdata_o()
  );

  dqi_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue2_ram (
    .clk_i  (clk_i),
    .we_i   (q2_we),
    .addr_i (l2.wr_addr),
    .wdata_i(idx_q),
    .rdata_o()
  );

  assign index_rejected_o         = rej_q;
  assign level1_outcome_o         = oc1_q;
  assign level2_outcome_o         = oc2_q;
  assign new_flags_o              = flags_q;
  assign level1_committed_count_o = rc1_q;
  assign level1_total_count_o     = rt1_q;
  assign level2_committed_count_o = rc2_q;
  assign level2_total_count_o     = rt2_q;

endmodule

### tb/tb.sv
// Self-checking testbench for the two-level dedup queue insert block.
module tb;
  import dqi_pkg::*;

  // Run bounds: the flag sweep after reset covers 1024 entries, then about 720 words
  // follow; the limit is many times what they need even under the heaviest stalls.
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned DRAIN_CYCLES  = 16;
  localparam int unsigned RANDOM_PHASES = 7;
  localparam int unsigned PHASE_WORDS   = 100;
  localparam int unsigned LONG_HOLD     = 80;
  localparam int unsigned REGIME_SWAP   = 240;
  localparam int unsigned REGIME_FREE   = 480;
  localparam int unsigned MAX_REPORTS   = 40;

  // Index 3 maps to no register; a write there must change nothing.
  localparam logic [CFG_IW-1:0] CFG_SPARE = 2'd3;

  localparam logic [FLAG_W-1:0] FLAG_LV1_COMMIT = 4'h1;
  localparam logic [FLAG_W-1:0] FLAG_LV1_PEND   = 4'h2;
  localparam logic [FLAG_W-1:0] FLAG_LV2_COMMIT = 4'h4;
  localparam logic [FLAG_W-1:0] FLAG_LV2_PEND   = 4'h8;

  typedef struct packed {
    logic              rejected;
    outcome_e          lvl1;
    outcome_e          lvl2;
    logic [FLAG_W-1:0] flags;
    logic [CNT_W-1:0]  lv1_commit_cnt;
    logic [CNT_W-1:0]  lv1_total_cnt;
    logic [CNT_W-1:0]  lv2_commit_cnt;
    logic [CNT_W-1:0]  lv2_total_cnt;
  } insert_result_t;

  // Mirror of the flag store, the four counts and the registers; it predicts one
  // result word per accepted input word and matches results in order.
  class insert_tracker;
    logic [FLAG_W-1:0] entry_flags [NUM_ENTRIES];
    logic [CNT_W-1:0]  committed [2];
    logic [CNT_W-1:0]  total [2];
    logic [CNT_W-1:0]  capacity [2];
    logic [CNT_W-1:0]  active_count;
    logic [FLAG_W-1:0] flags_now;
    insert_result_t    awaited_results [$];
    int unsigned       errors;
    int unsigned       words_seen;
    int unsigned       rejected_seen;
    int unsigned       reg_writes;
    int unsigned       outcome_seen [4];

    function new();
      foreach (entry_flags[i]) entry_flags[i] = '0;
      foreach (committed[l]) begin
        committed[l] = '0;
        total[l]     = '0;
        capacity[l]  = CAPACITY_RST;
      end
      active_count  = ACTIVE_COUNT_RST;
      errors        = 0;
      words_seen    = 0;
      rejected_seen = 0;
      reg_writes    = 0;
      foreach (outcome_seen[k]) outcome_seen[k] = 0;
    endfunction

    function void apply_reg(logic [CFG_IW-1:0] idx, logic [CNT_W-1:0] data);
      reg_writes++;
      case (idx)
        CFG_ACTIVE_COUNT:    active_count = data;
        CFG_CAPACITY_LEVEL1: capacity[0]  = data;
        CFG_CAPACITY_LEVEL2: capacity[1]  = data;
        default: ;
      endcase
    endfunction

    // Try one level on flags_now; an active level always ends with its pending bit set.
    function outcome_e place(int lvl, logic act);
      logic [FLAG_W-1:0] cbit;
      logic [FLAG_W-1:0] pbit;
      logic [CNT_W-1:0]  lim;
      logic [CNT_W-1:0]  slot;
      outcome_e          oc;
      cbit = (lvl != 0) ? FLAG_LV2_COMMIT : FLAG_LV1_COMMIT;
      pbit = (lvl != 0) ? FLAG_LV2_PEND : FLAG_LV1_PEND;
      lim  = (capacity[lvl] > QUEUE_DEPTH) ? CNT_W'(QUEUE_DEPTH) : capacity[lvl];
      slot = act ? total[lvl] : committed[lvl];
      oc   = OUT_ALREADY;
      if ((flags_now & (cbit | pbit)) == '0) begin
        if (slot < lim) begin
          if (total[lvl] != '1) total[lvl] = total[lvl] + 1'b1;
          if (act) begin
            oc = OUT_PENDING;
          end else begin
            committed[lvl] = committed[lvl] + 1'b1;
            flags_now      = flags_now | cbit;
            oc             = OUT_COMMIT;
          end
        end else begin
          oc = OUT_DROPPED;
        end
      end
      if (act) flags_now = flags_now | pbit;
      return oc;
    endfunction

    function void predict_insert(logic [ENTRY_W-1:0] idx, logic act1, logic act2);
      insert_result_t r;
      r          = '0;
      r.rejected = 1'b1;
      words_seen++;
      if (CNT_W'(idx) < active_count) begin
        flags_now        = entry_flags[idx];
        r.rejected       = 1'b0;
        r.lvl1           = place(0, act1);
        r.lvl2           = place(1, act2);
        entry_flags[idx] = flags_now;
        r.flags          = flags_now;
        outcome_seen[r.lvl1]++;
        outcome_seen[r.lvl2]++;
      end else begin
        rejected_seen++;
      end
      r.lv1_commit_cnt = committed[0];
      r.lv1_total_cnt  = total[0];
      r.lv2_commit_cnt = committed[1];
      r.lv2_total_cnt  = total[1];
      awaited_results.push_back(r);
    endfunction

    function void compare(string what, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
      end
    endfunction

    function void check_result(insert_result_t got);
      insert_result_t want;
      if (awaited_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result with nothing awaited, expected none actual %h", $time, got);
        return;
      end
      want = awaited_results.pop_front();
      compare("index_rejected", want.rejected, got.rejected);
      compare("level1_outcome", want.lvl1, got.lvl1);
      compare("level2_outcome", want.lvl2, got.lvl2);
      compare("new_flags", want.flags, got.flags);
      compare("level1_committed_count", want.lv1_commit_cnt, got.lv1_commit_cnt);
      compare("level1_total_count", want.lv1_total_cnt, got.lv1_total_cnt);
      compare("level2_committed_count", want.lv2_commit_cnt, got.lv2_commit_cnt);
      compare("level2_total_count", want.lv2_total_cnt, got.lv2_total_cnt);
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [ENTRY_W-1:0]  entry_index_i;
  logic                level1_active_i;
  logic                level2_active_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic                index_rejected_o;
  logic [1:0]          level1_outcome_o;
  logic [1:0]          level2_outcome_o;
  logic [FLAG_W-1:0]   new_flags_o;
  logic [CNT_W-1:0]    level1_committed_count_o;
  logic [CNT_W-1:0]    level1_total_count_o;
  logic [CNT_W-1:0]    level2_committed_count_o;
  logic [CNT_W-1:0]    level2_total_count_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CFG_IW-1:0]   cfg_index_i;
  logic [CNT_W-1:0]    cfg_data_i;

  insert_tracker sb;
  int unsigned   send_idle_pct;
  int unsigned   recv_idle_pct;
  int unsigned   words_sent = 0;
  int unsigned   cycle_count = 0;

  two_level_dedup_queue_insert dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // Offer one input word, idling first at the current rate, and hold it until taken.
  // Valid stays high on return so a following word can go out back to back.
  task automatic send_word(logic [ENTRY_W-1:0] idx, logic act1, logic act2);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    entry_index_i   <= idx;
    level1_active_i <= act1;
    level2_active_i <= act2;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.predict_insert(idx, act1, act2);
    words_sent++;
    // Swap the idle rates, then drop idling altogether for the last stretch.
    if (words_sent == REGIME_SWAP) begin
      send_idle_pct = 75;
      recv_idle_pct = 27;
    end else if (words_sent == REGIME_FREE) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  task automatic cfg_write(logic [CFG_IW-1:0] idx, logic [CNT_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.apply_reg(idx, data);
  endtask

  task automatic set_config(logic [CNT_W-1:0] act_cnt, logic [CNT_W-1:0] cap1,
                            logic [CNT_W-1:0] cap2);
    cfg_write(CFG_ACTIVE_COUNT, act_cnt);
    cfg_write(CFG_CAPACITY_LEVEL1, cap1);
    cfg_write(CFG_CAPACITY_LEVEL2, cap2);
    cfg_valid_i <= 1'b0;
  endtask

  // Drop valid, wait for every awaited result, then let the pipeline settle for SETTLE_CYCLES.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.awaited_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Capacity picks: the extremes, something at or just above the current fill, or anything.
  function automatic logic [CNT_W-1:0] pick_cap(logic [CNT_W-1:0] filled);
    case ($urandom_range(4))
      0:       return '0;
      1:       return CNT_W'(QUEUE_DEPTH);
      2:       return '1;
      3:       return (filled > 11'd2040) ? filled : filled + CNT_W'($urandom_range(6));
      default: return CNT_W'($urandom_range(2047));
    endcase
  endfunction

  function automatic logic [CNT_W-1:0] pick_active_count();
    case ($urandom_range(3))
      0:       return '1;
      1:       return CNT_W'(NUM_ENTRIES);
      2:       return CNT_W'($urandom_range(1023, 1));
      default: return CNT_W'($urandom_range(2047));
    endcase
  endfunction

  // Result side: check each accepted word, stall at the current rate, and twice hold
  // ready low for a long stretch so the block backs up and stalls its input.
  initial begin : result_sink
    insert_result_t got;
    int unsigned    hold_left;
    int unsigned    results_seen;
    hold_left    = 0;
    results_seen = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got.rejected       = index_rejected_o;
        got.lvl1           = outcome_e'(level1_outcome_o);
        got.lvl2           = outcome_e'(level2_outcome_o);
        got.flags          = new_flags_o;
        got.lv1_commit_cnt = level1_committed_count_o;
        got.lv1_total_cnt  = level1_total_count_o;
        got.lv2_commit_cnt = level2_committed_count_o;
        got.lv2_total_cnt  = level2_total_count_o;
        sb.check_result(got);
        results_seen++;
        if (results_seen == 100 || results_seen == 520) hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : stimulus
    logic [ENTRY_W-1:0] idx;
    logic [ENTRY_W-1:0] recent [$];
    int unsigned        roll;
    int unsigned        span;
    sb            = new();
    send_idle_pct = 27;
    recv_idle_pct = 75;
    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    entry_index_i   <= '0;
    level1_active_i <= 1'b0;
    level2_active_i <= 1'b0;
    cfg_valid_i     <= 1'b0;
    cfg_index_i     <= '0;
    cfg_data_i      <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset registers admit no index at all: both extremes come back rejected.
    send_word(10'd0, 1'b0, 1'b0);
    send_word(10'd1023, 1'b1, 1'b1);
    settle();

    // Full range of indices; a level one capacity above the depth must clamp to it.
    cfg_write(CFG_SPARE, '1);
    set_config(11'd1024, 11'd2047, 11'd1024);
    send_word(10'd0, 1'b0, 1'b0);      // committed append at both levels
    send_word(10'd0, 1'b1, 1'b1);      // already queued, pending bits still set
    send_word(10'd1023, 1'b1, 1'b1);   // pending append at both levels
    send_word(10'd512, 1'b0, 1'b1);
    send_word(10'd1, 1'b1, 1'b0);
    send_word(10'd1, 1'b0, 1'b0);      // pending bit alone blocks a committed append
    send_word(10'd341, 1'b0, 1'b0);    // committed append over a pending slot
    send_word(10'd682, 1'b1, 1'b1);
    send_word(10'd2, 1'b0, 1'b0);
    settle();

    // Level one capped at its current total, level two at zero: drops in both modes,
    // plus rejection right at the active count.
    set_config(11'd600, sb.total[0], 11'd0);
    send_word(10'd599, 1'b1, 1'b1);    // dropped while active, pending bits set
    send_word(10'd600, 1'b0, 1'b0);
    send_word(10'd3, 1'b0, 1'b0);      // level two dropped while inactive
    send_word(10'd1023, 1'b0, 1'b0);
    send_word(10'd4, 1'b1, 1'b0);
    settle();

    set_config(11'd1, 11'd0, 11'd1024);
    send_word(10'd0, 1'b1, 1'b0);
    send_word(10'd1, 1'b0, 1'b0);
    send_word(10'd0, 1'b0, 1'b1);

    // Random phases, each under fresh register settings. Mostly valid indices, with a
    // share of recent repeats so the already-queued paths see plenty of traffic.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      if (p == 0)
        set_config(11'd1024, 11'd1024, 11'd1024);
      else if (p == RANDOM_PHASES - 1)
        set_config('1, '1, '1);
      else
        set_config(pick_active_count(), pick_cap(sb.total[0]), pick_cap(sb.total[1]));
      span = (sb.active_count > NUM_ENTRIES) ? NUM_ENTRIES : sb.active_count;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        roll = $urandom_range(99);
        if (roll < 25 && recent.size() > 0)
          idx = recent[$urandom_range(recent.size() - 1)];
        else if (roll < 85 && span != 0)
          idx = ENTRY_W'($urandom_range(span - 1));
        else
          idx = ENTRY_W'($urandom_range(1023));
        recent.push_back(idx);
        if (recent.size() > 16) void'(recent.pop_front());
        send_word(idx, 1'($urandom_range(1)), 1'($urandom_range(1)));
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d words (%0d rejected) over %0d register writes",
             sb.words_seen, sb.rejected_seen, sb.reg_writes);
    $display("level outcomes: %0d already queued, %0d committed, %0d pending, %0d dropped",
             sb.outcome_seen[OUT_ALREADY], sb.outcome_seen[OUT_COMMIT],
             sb.outcome_seen[OUT_PENDING], sb.outcome_seen[OUT_DROPPED]);
    if (sb.errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
